// ===== rtl/uifr_pkg.sv =====
// Package for the idle-frame serial relay: payload types, event codes and sizes.
package uifr_pkg;

   // Frame buffer size and the widths that follow from it
   localparam int BUFFER_DEPTH = 64;
   localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
   localparam int POS_W        = $clog2(BUFFER_DEPTH + 1);

   // Idle timeout register
   localparam int          TICKS_W     = 16;
   localparam logic [15:0] TICKS_RESET = 16'd5000;

   // Event codes carried in the action field
   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_RX   = 2'd1;
   localparam logic [1:0] ACT_DONE = 2'd2;

   // Input beat
   typedef struct packed {
      logic [1:0] action;
      logic [7:0] rx_byte;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       port_select;
      logic       last_byte;
   } rsp_type;

   // Emit request from the control logic to the output stage
   typedef struct packed {
      logic valid;
      logic port_select;
      logic last_byte;
   } emit_type;

endpackage

// ===== rtl/uifr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module uifr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/uifr_ctrl.sv =====
// Relay control: frame positions, mode, port toggle and idle timer, one event per beat.
module uifr_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  uifr_pkg::req_type          req_data,
   input  logic [uifr_pkg::TICKS_W-1:0] idle_ticks,
   output logic                       wr_en,
   output logic [uifr_pkg::ADDR_W-1:0] wr_addr,
   output logic [7:0]                 wr_data,
   output logic                       rd_en,
   output logic [uifr_pkg::ADDR_W-1:0] rd_addr,
   output uifr_pkg::emit_type         emit
);

   logic [uifr_pkg::POS_W-1:0]   wpos_ff, wpos_in;
   logic [uifr_pkg::POS_W-1:0]   rpos_ff, rpos_in;
   logic [uifr_pkg::POS_W-1:0]   flen_ff, flen_in;
   logic                         tx_mode_ff, tx_mode_in;
   logic                         alt_port_ff, alt_port_in;
   logic [uifr_pkg::TICKS_W-1:0] idle_cnt_ff, idle_cnt_in;
   logic                         active_ff, active_in;

   logic [uifr_pkg::TICKS_W-1:0] cnt_inc;
   logic [uifr_pkg::TICKS_W-1:0] limit;
   logic [uifr_pkg::POS_W-1:0]   emit_pos;
   logic                         do_emit;

   // Saturating tick count and effective timeout (zero acts as one)
   assign cnt_inc = (idle_cnt_ff != '1) ? idle_cnt_ff + uifr_pkg::TICKS_W'(1) : idle_cnt_ff;
   assign limit   = (idle_ticks == '0) ? uifr_pkg::TICKS_W'(1) : idle_ticks;

   // Event decode and next state
   always_comb begin
      wpos_in     = wpos_ff;
      rpos_in     = rpos_ff;
      flen_in     = flen_ff;
      tx_mode_in  = tx_mode_ff;
      alt_port_in = alt_port_ff;
      idle_cnt_in = idle_cnt_ff;
      active_in   = active_ff;
      wr_en       = 1'b0;
      do_emit     = 1'b0;
      emit_pos    = rpos_ff;
      if (accept) begin
         unique case (req_data.action)
            uifr_pkg::ACT_RX: begin
               if (!tx_mode_ff) begin
                  // store while there is room; a dropped byte still counts as activity
                  if (wpos_ff < uifr_pkg::POS_W'(uifr_pkg::BUFFER_DEPTH)) begin
                     wr_en   = 1'b1;
                     wpos_in = wpos_ff + uifr_pkg::POS_W'(1);
                  end
                  idle_cnt_in = '0;
                  active_in   = 1'b1;
               end
            end
            uifr_pkg::ACT_DONE: begin
               if (tx_mode_ff) begin
                  idle_cnt_in = '0;
                  active_in   = 1'b1;
                  if (rpos_ff < flen_ff) begin
                     do_emit  = 1'b1;
                     emit_pos = rpos_ff;
                     rpos_in  = rpos_ff + uifr_pkg::POS_W'(1);
                  end
               end
            end
            uifr_pkg::ACT_TICK: begin
               if (cnt_inc < limit) begin
                  idle_cnt_in = cnt_inc;
               end else begin
                  idle_cnt_in = '0;
                  active_in   = 1'b0;
                  if (!tx_mode_ff) begin
                     // frame ended: switch port and send the first byte
                     if (active_ff && (wpos_ff != '0)) begin
                        alt_port_in = !alt_port_ff;
                        tx_mode_in  = 1'b1;
                        flen_in     = wpos_ff;
                        rpos_in     = uifr_pkg::POS_W'(1);
                        do_emit     = 1'b1;
                        emit_pos    = '0;
                     end
                  end else begin
                     // transmission timed out: back to receive, frame cleared
                     tx_mode_in = 1'b0;
                     wpos_in    = '0;
                     rpos_in    = '0;
                     flen_in    = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Buffer access
   assign wr_addr = wpos_ff[uifr_pkg::ADDR_W-1:0];
   assign wr_data = req_data.rx_byte;
   assign rd_en   = do_emit;
   assign rd_addr = emit_pos[uifr_pkg::ADDR_W-1:0];

   // Result flags use the updated port and frame length
   assign emit.valid       = do_emit;
   assign emit.port_select = alt_port_in;
   assign emit.last_byte   = ((emit_pos + uifr_pkg::POS_W'(1)) == flen_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff     <= '0;
         rpos_ff     <= '0;
         flen_ff     <= '0;
         tx_mode_ff  <= 1'b0;
         alt_port_ff <= 1'b0;
         idle_cnt_ff <= '0;
         active_ff   <= 1'b0;
      end else begin
         wpos_ff     <= wpos_in;
         rpos_ff     <= rpos_in;
         flen_ff     <= flen_in;
         tx_mode_ff  <= tx_mode_in;
         alt_port_ff <= alt_port_in;
         idle_cnt_ff <= idle_cnt_in;
         active_ff   <= active_in;
      end
   end

endmodule

// ===== rtl/uifr_out.sv =====
// Result path: read-pending stage and output register with stall handling.
module uifr_out (
   input  logic               clock,
   input  logic               reset,
   input  uifr_pkg::emit_type emit,
   input  logic [7:0]         rd_data,
   output logic               hold,
   output logic               rsp_valid,
   output uifr_pkg::rsp_type  rsp_data,
   input  logic               rsp_stall
);

   logic              pend_valid_ff, pend_valid_in;
   logic              pend_port_ff, pend_port_in;
   logic              pend_last_ff, pend_last_in;
   logic              out_valid_ff, out_valid_in;
   uifr_pkg::rsp_type out_data_ff, out_data_in;
   logic              advance;
   logic              move;

   // Output register frees when empty or taken this cycle
   assign advance = !out_valid_ff || !rsp_stall;
   assign move    = pend_valid_ff && advance;
   assign hold    = pend_valid_ff && !advance;

   // Pending stage waits for the buffer read data
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_port_in  = pend_port_ff;
      pend_last_in  = pend_last_ff;
      if (emit.valid) begin
         pend_valid_in = 1'b1;
         pend_port_in  = emit.port_select;
         pend_last_in  = emit.last_byte;
      end else if (move) begin
         pend_valid_in = 1'b0;
      end
   end

   // Output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (move) begin
         out_valid_in            = 1'b1;
         out_data_in.tx_byte     = rd_data;
         out_data_in.port_select = pend_port_ff;
         out_data_in.last_byte   = pend_last_ff;
      end else if (advance) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_port_ff <= pend_port_in;
      pend_last_ff <= pend_last_in;
      out_data_ff  <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== rtl/uart_idle_frame_relay_top.sv =====
// Top level of the idle-frame serial relay: buffer, control, result path, timeout register.
//
//   channel  direction  handshake          beat
//   req_     in         valid / stall      action, rx_byte
//   rsp_     out        valid / stall      tx_byte, port_select, last_byte
//   csr_     in         valid / ready      idle_ticks (16 bits)
//
// One event per cycle while req_stall is low; a result is registered first by the read of the
// 64-byte frame buffer, with its flags in the pending stage, then in the output register.
// Synchronous reset clears control state; buffer contents stay undefined.
// req_stall rises only while a result waits on both stages and rsp_stall is high.
// csr_ready is always high; idle_ticks resets to 5000.
module uart_idle_frame_relay_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  uifr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output uifr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_wdata
);

   logic [uifr_pkg::TICKS_W-1:0]  idle_ticks_ff, idle_ticks_in;
   logic                          accept;
   logic                          hold;
   logic                          wr_en;
   logic [uifr_pkg::ADDR_W-1:0]   wr_addr;
   logic [7:0]                    wr_data;
   logic                          rd_en;
   logic [uifr_pkg::ADDR_W-1:0]   rd_addr;
   logic [7:0]                    rd_data;
   uifr_pkg::emit_type            emit;

   // Timeout register
   assign csr_ready     = 1'b1;
   assign idle_ticks_in = (csr_valid && csr_ready) ? csr_wdata : idle_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ticks_ff <= uifr_pkg::TICKS_RESET;
      end else begin
         idle_ticks_ff <= idle_ticks_in;
      end
   end

   // Input handshake
   assign req_stall = hold;
   assign accept    = req_valid && !req_stall;

   uifr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .idle_ticks (idle_ticks_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .emit       (emit)
   );

   uifr_ram #(
      .WIDTH (8),
      .DEPTH (uifr_pkg::BUFFER_DEPTH)
   ) u_frame_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   uifr_out u_out (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .rd_data   (rd_data),
      .hold      (hold),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

// ===== rtl/uifr_checker.sv =====
// Port-level checks for the idle-frame serial relay, bound to the top level.
module uifr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input uifr_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input uifr_pkg::rsp_type rsp_data
);

   // A stalled result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // Nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A fresh result comes from an accepted beat, through the buffer read and output register
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching input beat");

   // Received bytes never produce a result
   a_rsp_not_rx: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_data.action != uifr_pkg::ACT_RX, 2))
      else $error("result caused by a received byte");

endmodule

bind uart_idle_frame_relay_top uifr_checker u_uifr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/uart_idle_frame_relay_top_tb.sv =====
// Self-checking testbench for the idle-frame serial relay: directed table, random frames, pressure.
module uart_idle_frame_relay_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Action code with no meaning to the relay
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // Short timeout used by the directed table
   localparam logic [15:0] DIRECTED_TICKS = 16'd4;

   localparam int                CYCLE_LIMIT   = 400000;
   localparam int                SETTLE_CYCLES = 6;
   localparam int                HOLD_CYCLES   = 300;
   localparam int                MAX_REPORTS   = 10;
   localparam uifr_pkg::rsp_type NO_RSP        = '0;

   // Random phases: timeout register value, item count, idling mode
   localparam int NUM_PHASES = 6;
   localparam int unsigned PHASE_TICKS [NUM_PHASES] = '{1, 0, 3, 65535, 2, 7};
   localparam int          PHASE_ITEMS [NUM_PHASES] = '{140, 100, 120, 60, 120, 110};
   localparam int          PHASE_MODE  [NUM_PHASES] = '{0, 0, 1, 1, 2, 2};

   typedef struct {
      logic [1:0]        action;
      logic [7:0]        data;
      int                reps;
      bit                typed;
      uifr_pkg::rsp_type want;
   } plan_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   uifr_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   uifr_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [15:0]       csr_wdata = '0;

   // Typed expectation that travels with a directed beat
   bit                req_typed = 1'b0;
   uifr_pkg::rsp_type req_typed_rsp = '0;

   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   logic        hold_req = 1'b0;
   logic        hold_done = 1'b0;
   int          hold_count = 0;
   int          mismatches = 0;
   int          cycle_count = 0;

   uifr_pkg::rsp_type expected_tx_q [$];
   uifr_pkg::req_type stim_q [$];
   plan_row_type      plan [18];

   // Predicted relay state
   logic [7:0]                 pred_frame [uifr_pkg::BUFFER_DEPTH];
   logic [uifr_pkg::POS_W-1:0] pred_wr;
   logic [uifr_pkg::POS_W-1:0] pred_rd;
   logic [uifr_pkg::POS_W-1:0] pred_len;
   logic                       pred_sending;
   logic                       pred_alt;
   logic [15:0]                pred_idle;
   logic                       pred_active;
   logic [15:0]                pred_ticks;

   uart_idle_frame_relay_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic uifr_pkg::rsp_type rsp_of(input logic [7:0] b, input logic ps,
                                                input logic last);
      uifr_pkg::rsp_type r;
      r.tx_byte     = b;
      r.port_select = ps;
      r.last_byte   = last;
      return r;
   endfunction

   task automatic relay_clear();
      for (int i = 0; i < uifr_pkg::BUFFER_DEPTH; i++) pred_frame[i] = '0;
      pred_wr      = '0;
      pred_rd      = '0;
      pred_len     = '0;
      pred_sending = 1'b0;
      pred_alt     = 1'b0;
      pred_idle    = '0;
      pred_active  = 1'b0;
      pred_ticks   = uifr_pkg::TICKS_RESET;
   endtask

   // Byte at a frame position, as the transmitter would see it
   function automatic uifr_pkg::rsp_type frame_out(input logic [uifr_pkg::POS_W-1:0] pos);
      uifr_pkg::rsp_type r;
      r.tx_byte     = pred_frame[pos[uifr_pkg::ADDR_W-1:0]];
      r.port_select = pred_alt;
      r.last_byte   = (pos + 1'b1 == pred_len);
      return r;
   endfunction

   // One event into the predicted relay; returns 1 when a byte goes out
   function automatic bit relay_predict(input uifr_pkg::req_type beat,
                                        output uifr_pkg::rsp_type res);
      logic [15:0] lim;
      res = '0;
      lim = (pred_ticks == 16'd0) ? 16'd1 : pred_ticks;
      case (beat.action)
         uifr_pkg::ACT_RX: begin
            if (!pred_sending) begin
               // full buffer drops the byte but still counts as activity
               if (pred_wr < uifr_pkg::BUFFER_DEPTH) begin
                  pred_frame[pred_wr[uifr_pkg::ADDR_W-1:0]] = beat.rx_byte;
                  pred_wr = pred_wr + 1'b1;
               end
               pred_idle   = '0;
               pred_active = 1'b1;
            end
            return 1'b0;
         end
         uifr_pkg::ACT_DONE: begin
            if (!pred_sending) return 1'b0;
            pred_idle   = '0;
            pred_active = 1'b1;
            if (pred_rd < pred_len) begin
               res    = frame_out(pred_rd);
               pred_rd = pred_rd + 1'b1;
               return 1'b1;
            end
            return 1'b0;
         end
         uifr_pkg::ACT_TICK: begin
            if (pred_idle != 16'hFFFF) pred_idle = pred_idle + 1'b1;
            if (pred_idle < lim) return 1'b0;
            pred_idle = '0;
            if (!pred_sending) begin
               if (pred_active && pred_wr != '0) begin
                  pred_alt     = !pred_alt;
                  pred_sending = 1'b1;
                  pred_active  = 1'b0;
                  pred_len     = pred_wr;
                  pred_rd      = uifr_pkg::POS_W'(1);
                  res          = frame_out('0);
                  return 1'b1;
               end
               pred_active = 1'b0;
               return 1'b0;
            end
            // transmit timeout: back to receive, frame cleared
            pred_sending = 1'b0;
            pred_active  = 1'b0;
            pred_wr      = '0;
            pred_rd      = '0;
            pred_len     = '0;
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic log_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
   endtask

   // Monitor: check results first, then predict from the accepted input beat
   always @(posedge clock) begin : monitor
      uifr_pkg::rsp_type want;
      uifr_pkg::rsp_type pred_rsp;
      bit                has_rsp;
      if (reset) begin
         relay_clear();
         expected_tx_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_tx_q.size() == 0) begin
               log_mismatch($sformatf("unexpected beat tx_byte %02h port %b last %b",
                            rsp_data.tx_byte, rsp_data.port_select, rsp_data.last_byte));
            end else begin
               want = expected_tx_q.pop_front();
               if (rsp_data.tx_byte !== want.tx_byte ||
                   rsp_data.port_select !== want.port_select ||
                   rsp_data.last_byte !== want.last_byte)
                  log_mismatch($sformatf("tx_byte %02h/%02h port %b/%b last %b/%b (exp/act)",
                               want.tx_byte, rsp_data.tx_byte, want.port_select,
                               rsp_data.port_select, want.last_byte, rsp_data.last_byte));
            end
         end
         if (csr_valid && csr_ready) pred_ticks = csr_wdata;
         if (req_valid && !req_stall) begin
            has_rsp = relay_predict(req_data, pred_rsp);
            if (req_typed) expected_tx_q.push_back(req_typed_rsp);
            else if (has_rsp) expected_tx_q.push_back(pred_rsp);
         end
      end
   end

   // Receiver: random stall, or a long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         hold_count <= 0;
         hold_done  <= 1'b0;
      end else if (hold_req && !hold_done) begin
         rsp_stall <= 1'b1;
         if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         if (!hold_req) begin
            hold_count <= 0;
            hold_done  <= 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic send_beat(input uifr_pkg::req_type beat, input bit typed,
                            input uifr_pkg::rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data      <= beat;
      req_typed     <= typed;
      req_typed_rsp <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic run_queue();
      while (stim_q.size() != 0) send_beat(stim_q.pop_front(), 1'b0, NO_RSP);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (expected_tx_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ticks(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 16; recv_idle_pct = 76; end
         1: begin send_idle_pct = 76; recv_idle_pct = 16; end
         default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
   endtask

   function automatic uifr_pkg::req_type noise_beat();
      uifr_pkg::req_type b;
      b.action  = 2'($urandom_range(3));
      b.rx_byte = 8'($urandom);
      return b;
   endfunction

   function automatic uifr_pkg::req_type event_beat(input logic [1:0] act);
      uifr_pkg::req_type b;
      b.action  = act;
      b.rx_byte = 8'($urandom);
      return b;
   endfunction

   // Mostly well-formed frames (only noise when lim exceeds 64): bytes, idle timeout, done events, idle timeout
   task automatic queue_frames(input int target, input int unsigned lim);
      int n;
      int d;
      while (stim_q.size() < target) begin
         if (lim > 64 || $urandom_range(7) == 0) begin
            n = $urandom_range(15, 5);
            repeat (n) stim_q.push_back(noise_beat());
         end else begin
            n = ($urandom_range(9) == 0) ?
                $urandom_range(uifr_pkg::BUFFER_DEPTH + 6, uifr_pkg::BUFFER_DEPTH - 3) :
                $urandom_range(8, 1);
            repeat (n) begin
               if ($urandom_range(11) == 0) stim_q.push_back(noise_beat());
               stim_q.push_back(event_beat(uifr_pkg::ACT_RX));
            end
            repeat (lim) stim_q.push_back(event_beat(uifr_pkg::ACT_TICK));
            d = $urandom_range(n + 2, 0);
            repeat (d) begin
               if ($urandom_range(11) == 0) stim_q.push_back(noise_beat());
               stim_q.push_back(event_beat(uifr_pkg::ACT_DONE));
            end
            repeat (lim) stim_q.push_back(event_beat(uifr_pkg::ACT_TICK));
         end
      end
   endtask

   initial begin : stimulus
      uifr_pkg::req_type b;
      int unsigned       lim;
      // directed rows run with a timeout of 4 ticks
      plan = '{
         '{uifr_pkg::ACT_TICK, 8'h00, 3, 1'b0, NO_RSP},           // nothing stored yet
         '{uifr_pkg::ACT_DONE, 8'h55, 1, 1'b0, NO_RSP},           // done in receive mode
         '{ACT_UNUSED,         8'hC3, 1, 1'b0, NO_RSP},
         '{uifr_pkg::ACT_RX,   8'h00, 1, 1'b0, NO_RSP},
         '{uifr_pkg::ACT_RX,   8'hFF, 1, 1'b0, NO_RSP},
         '{uifr_pkg::ACT_RX,   8'hA5, 1, 1'b0, NO_RSP},
         '{uifr_pkg::ACT_TICK, 8'h00, 3, 1'b0, NO_RSP},
         '{uifr_pkg::ACT_TICK, 8'hFF, 1, 1'b1, rsp_of(8'h00, 1'b1, 1'b0)},
         '{uifr_pkg::ACT_RX,   8'h12, 1, 1'b0, NO_RSP},           // byte while sending
         '{uifr_pkg::ACT_DONE, 8'h00, 1, 1'b1, rsp_of(8'hFF, 1'b1, 1'b0)},
         '{ACT_UNUSED,         8'h00, 1, 1'b0, NO_RSP},
         '{uifr_pkg::ACT_DONE, 8'hFF, 1, 1'b1, rsp_of(8'hA5, 1'b1, 1'b1)},
         '{uifr_pkg::ACT_DONE, 8'h00, 1, 1'b0, NO_RSP},           // done after last byte
         '{uifr_pkg::ACT_TICK, 8'h00, 4, 1'b0, NO_RSP},           // back to receive
         '{uifr_pkg::ACT_RX,   8'h3C, 1, 1'b0, NO_RSP},
         '{uifr_pkg::ACT_TICK, 8'h00, 3, 1'b0, NO_RSP},
         '{uifr_pkg::ACT_TICK, 8'h00, 1, 1'b1, rsp_of(8'h3C, 1'b0, 1'b1)},
         '{uifr_pkg::ACT_TICK, 8'h00, 4, 1'b0, NO_RSP}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      set_idling(0);
      write_ticks(DIRECTED_TICKS);

      // Directed table
      foreach (plan[i]) begin
         b.action  = plan[i].action;
         b.rx_byte = plan[i].data;
         repeat (plan[i].reps) send_beat(b, plan[i].typed, plan[i].want);
      end

      // Random phases, timeout written while the relay is quiet
      for (int p = 0; p < NUM_PHASES; p++) begin
         req_valid <= 1'b0;
         wait_drained();
         write_ticks(16'(PHASE_TICKS[p]));
         set_idling(PHASE_MODE[p]);
         lim = (PHASE_TICKS[p] == 0) ? 1 : PHASE_TICKS[p];
         queue_frames(PHASE_ITEMS[p], lim);
         run_queue();
      end

      // Pressure: long receiver hold while a frame streams out
      req_valid <= 1'b0;
      wait_drained();
      write_ticks(16'd1);
      set_idling(2);
      hold_req <= 1'b1;
      // two timeouts leave the relay in receive mode
      repeat (2) stim_q.push_back(event_beat(uifr_pkg::ACT_TICK));
      repeat (12) stim_q.push_back(event_beat(uifr_pkg::ACT_RX));
      stim_q.push_back(event_beat(uifr_pkg::ACT_TICK));
      repeat (11) stim_q.push_back(event_beat(uifr_pkg::ACT_DONE));
      run_queue();
      while (!hold_done) @(posedge clock);
      hold_req  <= 1'b0;
      req_valid <= 1'b0;
      // sender pauses until every byte is out
      wait_drained();
      queue_frames(60, 1);
      run_queue();

      req_valid <= 1'b0;
      wait_drained();
      if (expected_tx_q.size() != 0)
         log_mismatch($sformatf("%0d expected beats never arrived", expected_tx_q.size()));

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
